// ----- hdl/rhpc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package rhpc_pkg;

	localparam int FRACTION_BITS_DEF = 16;
	localparam int TABLE_BITS        = 24;
	localparam int ATAN_ENTRIES      = 28;
	localparam longint SQRT3_Q24     = 64'sd29058991;
	localparam int SAT_Q_BITS        = 8;
	localparam int INV3_MUL          = 683;
	localparam int INV3_SHIFT        = 11;

	localparam longint ATAN_Q24 [ATAN_ENTRIES] = '{
		754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
		15018523, 7509720, 3754917, 1877466, 938734, 469367, 234684, 117342,
		58671, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7
	};

	typedef struct packed {
		logic [7:0] intensity;
		logic       grey;
		logic       b_gt_g;
		logic       sum_zero;
	} side_t;

	function automatic longint rescale(longint t, int f);
		int s;
		s = TABLE_BITS - f;
		if (s == 0) begin
			return t;
		end
		return (t + (64'sd1 <<< (s - 1))) >>> s;
	endfunction

	function automatic longint atan_scaled(int i, int f);
		return rescale(ATAN_Q24[i], f);
	endfunction

	function automatic longint sqrt3_scaled(int f);
		return rescale(SQRT3_Q24, f);
	endfunction

endpackage
`default_nettype wire

// ----- hdl/rhpc_pix_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
interface rhpc_pix_if;
	logic       valid;
	logic       ready;
	logic [7:0] blue;
	logic [7:0] green;
	logic [7:0] red;

	modport source (output valid, output blue, output green, output red, input ready);
	modport sink (input valid, input blue, input green, input red, output ready);
endinterface
`default_nettype wire

// ----- hdl/rhpc_hsi_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
interface rhpc_hsi_if;
	logic       valid;
	logic       ready;
	logic [7:0] hue_half_degrees;
	logic [7:0] saturation;
	logic [7:0] intensity;

	modport source (output valid, output hue_half_degrees, output saturation,
		output intensity, input ready);
	modport sink (input valid, input hue_half_degrees, input saturation,
		input intensity, output ready);
endinterface
`default_nettype wire

// ----- hdl/rhpc_cordic.sv -----
`timescale 1ns / 1ps
`default_nettype none
module rhpc_cordic #(
	parameter int FRACTION_BITS = rhpc_pkg::FRACTION_BITS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           en,
	input  wire logic signed [FRACTION_BITS+11:0] x_in,
	input  wire logic signed [FRACTION_BITS+11:0] y_in,
	input  wire logic signed [FRACTION_BITS+10:0] z_in,
	output logic signed [FRACTION_BITS+10:0]      z_out
);
	import rhpc_pkg::*;

	localparam int N  = FRACTION_BITS + 4;
	localparam int W  = FRACTION_BITS + 12;
	localparam int ZW = FRACTION_BITS + 11;

	logic signed [W-1:0]  x_s [N+1];
	logic signed [W-1:0]  y_s [N+1];
	logic signed [ZW-1:0] z_s [N+1];

	assign x_s[0] = x_in;
	assign y_s[0] = y_in;
	assign z_s[0] = z_in;

	for (genvar i = 0; i < N; i++) begin : g_step
		localparam logic signed [ZW-1:0] A = ZW'(atan_scaled(i, FRACTION_BITS));
		logic signed [W-1:0] xs;
		logic signed [W-1:0] ys;
		assign xs = x_s[i] >>> i;
		assign ys = y_s[i] >>> i;
		always_ff @(posedge clk) begin
			if (en) begin
				if (y_s[i] > 0) begin
					x_s[i+1] <= x_s[i] + ys;
					y_s[i+1] <= y_s[i] - xs;
					z_s[i+1] <= z_s[i] + A;
				end else begin
					x_s[i+1] <= x_s[i] - ys;
					y_s[i+1] <= y_s[i] + xs;
					z_s[i+1] <= z_s[i] - A;
				end
			end
		end
	end

	assign z_out = z_s[N];
endmodule
`default_nettype wire

// ----- hdl/rhpc_sat_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
module rhpc_sat_div #(
	parameter int DEPTH = rhpc_pkg::FRACTION_BITS_DEF + 4
) (
	input  wire logic            clk,
	input  wire logic            en,
	input  wire logic [17:0]     num,
	input  wire logic [9:0]      den,
	input  rhpc_pkg::side_t      side_in,
	output logic [7:0]           sat,
	output rhpc_pkg::side_t      side_out
);
	import rhpc_pkg::*;

	logic [17:0]           rem_s  [DEPTH+1];
	logic [9:0]            den_s  [DEPTH+1];
	logic [SAT_Q_BITS-1:0] quo_s  [DEPTH+1];
	side_t                 side_s [DEPTH+1];

	assign rem_s[0]  = num;
	assign den_s[0]  = den;
	assign quo_s[0]  = '0;
	assign side_s[0] = side_in;

	for (genvar k = 0; k < DEPTH; k++) begin : g_stage
		if (k < SAT_Q_BITS) begin : g_div
			logic [17:0] dsh;
			logic        take;
			assign dsh  = 18'(den_s[k]) << (SAT_Q_BITS - 1 - k);
			assign take = rem_s[k] >= dsh;
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k+1] <= take ? rem_s[k] - dsh : rem_s[k];
					quo_s[k+1] <= quo_s[k] | (SAT_Q_BITS'(take) << (SAT_Q_BITS - 1 - k));
					den_s[k+1] <= den_s[k];
					side_s[k+1] <= side_s[k];
				end
			end
		end else begin : g_hold
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k+1]  <= rem_s[k];
					quo_s[k+1]  <= quo_s[k];
					den_s[k+1]  <= den_s[k];
					side_s[k+1] <= side_s[k];
				end
			end
		end
	end

	logic [10:0] two_r;
	logic        up;
	assign two_r = {rem_s[DEPTH][9:0], 1'b0};
	assign up    = (two_r > {1'b0, den_s[DEPTH]})
		|| ((two_r == {1'b0, den_s[DEPTH]}) && quo_s[DEPTH][0]);
	assign sat      = side_s[DEPTH].sum_zero ? 8'd0 : quo_s[DEPTH] + 8'(up);
	assign side_out = side_s[DEPTH];
endmodule
`default_nettype wire

// ----- hdl/rgb_to_hsi_pixel_converter_unit.sv -----
// channel | dir | modport     | payload
// pix     | in  | rhpc_pix_if | blue, green, red
// hsi     | out | rhpc_hsi_if | hue_half_degrees, saturation, intensity
//
// One pixel per clock unless hsi stalls; the pipeline is a prep stage, one
// CORDIC rotation per stage and an output register.
// The whole pipeline advances together when the output register is empty or taken.
// arst_n clears the valid bits only; no clearing pass.
// A stall at hsi holds every stage and drops pix.ready.
`timescale 1ns / 1ps
`default_nettype none
module rgb_to_hsi_pixel_converter_unit #(
	parameter int FRACTION_BITS = rhpc_pkg::FRACTION_BITS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	rhpc_pix_if.sink   pix,
	rhpc_hsi_if.source hsi
);
	import rhpc_pkg::*;

	localparam int N   = FRACTION_BITS + 4;
	localparam int W   = FRACTION_BITS + 12;
	localparam int ZW  = FRACTION_BITS + 11;
	localparam int TOT = N + 2;
	localparam logic [FRACTION_BITS+1:0] SQRT3_F = (FRACTION_BITS+2)'(sqrt3_scaled(FRACTION_BITS));
	localparam logic signed [ZW-1:0] QUARTER = ZW'(90) <<< FRACTION_BITS;
	localparam logic signed [ZW-1:0] FULL    = ZW'(360) <<< FRACTION_BITS;

	logic en;
	logic [TOT-1:0] valid_q;

	assign en        = !hsi.valid || hsi.ready;
	assign pix.ready = en;
	assign hsi.valid = valid_q[TOT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (en) begin
			valid_q <= {valid_q[TOT-2:0], pix.valid};
		end
	end

	// prep
	logic signed [10:0]            dx;
	logic signed [8:0]             dy;
	logic signed [FRACTION_BITS+10:0] py;
	logic signed [W-1:0]           x0, y0, xr, yr;
	logic signed [ZW-1:0]          zr;
	logic [9:0]                    sum;
	logic [7:0]                    mn;
	logic [9:0]                    spread;
	logic [20:0]                   i3;
	side_t                         side_c;

	always_comb begin
		dx  = 11'(signed'({3'b0, pix.red}) <<< 1) - signed'({3'b0, pix.green})
			- signed'({3'b0, pix.blue});
		dy  = signed'({1'b0, pix.green}) - signed'({1'b0, pix.blue});
		py  = (FRACTION_BITS+11)'(dy * signed'({1'b0, SQRT3_F}));
		x0  = W'(dx) <<< FRACTION_BITS;
		y0  = W'(py);
		xr  = x0;
		yr  = y0;
		zr  = '0;
		if (x0 < 0) begin
			if (y0 >= 0) begin
				xr = y0;
				yr = -x0;
				zr = QUARTER;
			end else begin
				xr = -y0;
				yr = x0;
				zr = -QUARTER;
			end
		end
		sum    = 10'(pix.red) + 10'(pix.green) + 10'(pix.blue);
		mn     = (pix.red < pix.green) ? pix.red : pix.green;
		mn     = (mn < pix.blue) ? mn : pix.blue;
		spread = sum - 10'(3 * 10'(mn));
		i3     = 21'((11'(sum) + 11'd1) * 11'(INV3_MUL));
		side_c.intensity = i3[INV3_SHIFT+7:INV3_SHIFT];
		side_c.grey      = (pix.red == pix.green) && (pix.green == pix.blue);
		side_c.b_gt_g    = pix.blue > pix.green;
		side_c.sum_zero  = sum == '0;
	end

	logic signed [W-1:0]  x_s1, y_s1;
	logic signed [ZW-1:0] z_s1;
	logic [17:0]          num_s1;
	logic [9:0]           den_s1;
	side_t                side_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1    <= xr;
			y_s1    <= yr;
			z_s1    <= zr;
			num_s1  <= 18'(18'(spread) * 18'd255);
			den_s1  <= sum;
			side_s1 <= side_c;
		end
	end

	logic signed [ZW-1:0] z_n;
	logic [7:0]           sat_n;
	side_t                side_n;

	rhpc_cordic #(.FRACTION_BITS(FRACTION_BITS)) u_cordic (
		.clk   (clk),
		.en    (en),
		.x_in  (x_s1),
		.y_in  (y_s1),
		.z_in  (z_s1),
		.z_out (z_n)
	);

	rhpc_sat_div #(.DEPTH(N)) u_div (
		.clk      (clk),
		.en       (en),
		.num      (num_s1),
		.den      (den_s1),
		.side_in  (side_s1),
		.sat      (sat_n),
		.side_out (side_n)
	);

	// hue rounding
	logic signed [ZW-1:0]       h_adj, h_cl;
	logic [FRACTION_BITS:0]     h_rem;
	logic [7:0]                 h_q;
	logic                       h_up;
	logic [7:0]                 hue_c;

	always_comb begin
		h_adj = side_n.b_gt_g ? z_n + FULL : z_n;
		h_cl  = h_adj;
		if (h_adj < 0) begin
			h_cl = '0;
		end else if (h_adj > FULL) begin
			h_cl = FULL;
		end
		h_q   = h_cl[FRACTION_BITS+8:FRACTION_BITS+1];
		h_rem = h_cl[FRACTION_BITS:0];
		h_up  = (h_rem > ((FRACTION_BITS+1)'(1) << FRACTION_BITS))
			|| ((h_rem == ((FRACTION_BITS+1)'(1) << FRACTION_BITS)) && h_q[0]);
		hue_c = side_n.grey ? 8'd0 : h_q + 8'(h_up);
	end

	logic [7:0] hue_q, sat_q, int_q;

	always_ff @(posedge clk) begin
		if (en) begin
			hue_q <= hue_c;
			sat_q <= sat_n;
			int_q <= side_n.intensity;
		end
	end

	assign hsi.hue_half_degrees = hue_q;
	assign hsi.saturation       = sat_q;
	assign hsi.intensity        = int_q;

	a_hue_range : assert property (@(posedge clk) disable iff (!arst_n)
		hsi.valid |-> hsi.hue_half_degrees <= 8'd180)
		else $error("hue out of range");
	a_stall_hold : assert property (@(posedge clk) disable iff (!arst_n)
		hsi.valid && !hsi.ready |-> !pix.ready)
		else $error("request taken during output stall");
	a_bubble_ready : assert property (@(posedge clk) disable iff (!arst_n)
		!hsi.valid |-> pix.ready)
		else $error("input held while output empty");
endmodule
`default_nettype wire
